>>> rtl/i2cbm_pkg.sv
`default_nettype none

package i2cbm_pkg;

	// Width of the phase wait counter and of the delay register.
	localparam int unsigned DELAY_BITS = 16;
	localparam logic [DELAY_BITS-1:0] DELAY_RST = DELAY_BITS'(5);

	// Commands carried in the action field; codes above stop act as ticks.
	typedef enum logic [2:0] {
		ACT_TICK  = 3'd0,
		ACT_START = 3'd1,
		ACT_WRITE = 3'd2,
		ACT_READ  = 3'd3,
		ACT_STOP  = 3'd4
	} action_t;

	// Bus phases; each line change is followed by a wait of delay ticks.
	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_ST_A     = 5'd1,
		PH_ST_B     = 5'd2,
		PH_ST_C     = 5'd3,
		PH_WR_SETUP = 5'd4,
		PH_WR_HIGH  = 5'd5,
		PH_WR_LOW   = 5'd6,
		PH_AK_SETUP = 5'd7,
		PH_AK_HIGH  = 5'd8,
		PH_AK_LOW   = 5'd9,
		PH_SP_A     = 5'd10,
		PH_SP_B     = 5'd11,
		PH_SP_C     = 5'd12,
		PH_RD_PRE   = 5'd13,
		PH_RD_HIGH  = 5'd14,
		PH_RD_LOW   = 5'd15,
		PH_RA_HIGH  = 5'd16,
		PH_RA_LOW   = 5'd17
	} phase_t;

	// Complete controller state.
	typedef struct packed {
		phase_t                phase;
		logic [3:0]            bit_count;
		logic [7:0]            shift_byte;
		logic [DELAY_BITS-1:0] wait_count;
		logic                  scl_out;
		logic                  sda_out;
		logic                  sda_dir_out;
		logic                  nack_to_send;
		logic                  error_flag;
		logic [7:0]            received_byte;
	} state_t;

	// Per-item event flags from the step logic.
	typedef struct packed {
		logic done;
		logic rvalid;
		logic rej;
	} flags_t;

	localparam state_t STATE_RST = '{
		phase:         PH_IDLE,
		bit_count:     4'd0,
		shift_byte:    8'd0,
		wait_count:    '0,
		scl_out:       1'b1,
		sda_out:       1'b1,
		sda_dir_out:   1'b1,
		nack_to_send:  1'b0,
		error_flag:    1'b0,
		received_byte: 8'd0
	};

endpackage

`default_nettype wire

>>> rtl/i2c_bit_level_master_core.sv
`default_nettype none

// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------
// input    | in_valid / in_ready       | action, sda_level, target_addr, read_dir,
//          |                           | data_byte, send_nack
// result   | out_valid / out_ready     | scl_level, sda_release, sda_output_enable,
//          |                           | busy_res, done_res, read_data, read_valid,
//          |                           | ack_error, rejected
// config   | cfg_we (no wait)          | cfg_wdata -> delay_ticks
//
// For each item, the state update and its result are computed in a single pass
// and land in the state and result registers on the accepting edge.
// One result per item, in the cycle after its item; items may follow every cycle.
// The input is held off only while a result waits and out_ready is low.
// Reset (arst_n low) returns the bus to idle with both lines released.

module i2c_bit_level_master_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [i2cbm_pkg::DELAY_BITS-1:0] cfg_wdata,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [2:0]                       action,
	input  wire logic                             sda_level,
	input  wire logic [6:0]                       target_addr,
	input  wire logic                             read_dir,
	input  wire logic [7:0]                       data_byte,
	input  wire logic                             send_nack,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  scl_level,
	output logic                                  sda_release,
	output logic                                  sda_output_enable,
	output logic                                  busy_res,
	output logic                                  done_res,
	output logic [7:0]                            read_data,
	output logic                                  read_valid,
	output logic                                  ack_error,
	output logic                                  rejected
);
	import i2cbm_pkg::*;

	logic [DELAY_BITS-1:0] delay_q;
	state_t                state_q;
	state_t                state_nxt;
	flags_t                flags;
	logic                  accept;
	logic                  out_valid_q;
	state_t                res_q;
	flags_t                res_flags_q;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	// Phase delay register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RST;
		end else if (cfg_we) begin
			delay_q <= cfg_wdata;
		end
	end

	i2cbm_step u_step (
		.cur         (state_q),
		.action      (action),
		.sda_level   (sda_level),
		.target_addr (target_addr),
		.read_dir    (read_dir),
		.data_byte   (data_byte),
		.send_nack   (send_nack),
		.delay_ticks (delay_q),
		.nxt         (state_nxt),
		.flags       (flags)
	);

	// Controller state advances once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RST;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// Result payload is captured with the item that produced it.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q       <= state_nxt;
			res_flags_q <= flags;
		end
	end

	assign out_valid         = out_valid_q;
	assign scl_level         = res_q.scl_out;
	assign sda_release       = res_q.sda_out;
	assign sda_output_enable = res_q.sda_dir_out;
	assign busy_res          = (res_q.phase != PH_IDLE);
	assign done_res          = res_flags_q.done;
	assign read_data         = res_q.received_byte;
	assign read_valid        = res_flags_q.rvalid;
	assign ack_error         = res_q.error_flag;
	assign rejected          = res_flags_q.rej;

endmodule

`default_nettype wire

>>> rtl/i2cbm_step.sv
`default_nettype none

module i2cbm_step (
	input  wire i2cbm_pkg::state_t                   cur,
	input  wire logic [2:0]                          action,
	input  wire logic                                sda_level,
	input  wire logic [6:0]                          target_addr,
	input  wire logic                                read_dir,
	input  wire logic [7:0]                          data_byte,
	input  wire logic                                send_nack,
	input  wire logic [i2cbm_pkg::DELAY_BITS-1:0]    delay_ticks,
	output i2cbm_pkg::state_t                        nxt,
	output i2cbm_pkg::flags_t                        flags
);
	import i2cbm_pkg::*;

	logic                  is_cmd;
	logic [DELAY_BITS-1:0] load_val;
	logic [DELAY_BITS-1:0] wait_dec;
	logic [3:0]            bc_inc;

	// A zero delay still waits one tick per phase.
	assign load_val = (delay_ticks == '0) ? DELAY_BITS'(1) : delay_ticks;
	assign wait_dec = (cur.wait_count != '0) ? cur.wait_count - DELAY_BITS'(1) : '0;
	assign bc_inc   = cur.bit_count + 4'd1;
	assign is_cmd   = (action == ACT_START) || (action == ACT_WRITE) ||
	                  (action == ACT_READ) || (action == ACT_STOP);

	// Next state for one item: either a command or one tick of the wait.
	always_comb begin
		nxt   = cur;
		flags = '0;
		if (is_cmd) begin
			if (cur.phase != PH_IDLE) begin
				flags.rej = 1'b1;
			end else if (action == ACT_START) begin
				nxt.error_flag  = 1'b0;
				nxt.shift_byte  = {target_addr, read_dir};
				nxt.bit_count   = 4'd0;
				nxt.sda_dir_out = 1'b1;
				nxt.sda_out     = 1'b1;
				nxt.scl_out     = 1'b1;
				nxt.wait_count  = load_val;
				nxt.phase       = PH_ST_A;
			end else if (action == ACT_STOP) begin
				nxt.sda_dir_out = 1'b1;
				nxt.sda_out     = 1'b0;
				nxt.wait_count  = load_val;
				nxt.phase       = PH_SP_A;
			end else if (cur.error_flag) begin
				flags.rej = 1'b1;
			end else if (action == ACT_WRITE) begin
				nxt.shift_byte  = data_byte;
				nxt.bit_count   = 4'd0;
				nxt.sda_dir_out = 1'b1;
				nxt.sda_out     = data_byte[7];
				nxt.wait_count  = load_val;
				nxt.phase       = PH_WR_SETUP;
			end else begin
				nxt.nack_to_send = send_nack;
				nxt.shift_byte   = 8'd0;
				nxt.bit_count    = 4'd0;
				nxt.sda_out      = 1'b1;
				nxt.sda_dir_out  = 1'b0;
				nxt.wait_count   = load_val;
				nxt.phase        = PH_RD_PRE;
			end
		end else if (cur.phase != PH_IDLE) begin
			nxt.wait_count = wait_dec;
			if (wait_dec == '0) begin
				case (cur.phase)
					PH_ST_A: begin
						nxt.sda_out = 1'b0; nxt.wait_count = load_val; nxt.phase = PH_ST_B;
					end
					PH_ST_B: begin
						nxt.scl_out = 1'b0; nxt.wait_count = load_val; nxt.phase = PH_ST_C;
					end
					PH_ST_C: begin
						nxt.sda_dir_out = 1'b1;
						nxt.sda_out     = cur.shift_byte[7];
						nxt.wait_count  = load_val;
						nxt.phase       = PH_WR_SETUP;
					end
					PH_WR_SETUP: begin
						nxt.scl_out = 1'b1; nxt.wait_count = load_val; nxt.phase = PH_WR_HIGH;
					end
					PH_WR_HIGH: begin
						nxt.scl_out = 1'b0; nxt.wait_count = load_val; nxt.phase = PH_WR_LOW;
					end
					PH_WR_LOW: begin
						nxt.bit_count  = bc_inc;
						nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
						nxt.wait_count = load_val;
						if (bc_inc < 4'd8) begin
							nxt.sda_dir_out = 1'b1;
							nxt.sda_out     = cur.shift_byte[6];
							nxt.phase       = PH_WR_SETUP;
						end else begin
							nxt.sda_dir_out = 1'b0;
							nxt.sda_out     = 1'b1;
							nxt.phase       = PH_AK_SETUP;
						end
					end
					PH_AK_SETUP: begin
						nxt.scl_out = 1'b1; nxt.wait_count = load_val; nxt.phase = PH_AK_HIGH;
					end
					PH_AK_HIGH: begin
						if (sda_level) nxt.error_flag = 1'b1;
						nxt.scl_out    = 1'b0;
						nxt.wait_count = load_val;
						nxt.phase      = PH_AK_LOW;
					end
					PH_AK_LOW: begin
						// A NACK sends the stop condition without software help.
						if (cur.error_flag) begin
							nxt.sda_dir_out = 1'b1;
							nxt.sda_out     = 1'b0;
							nxt.wait_count  = load_val;
							nxt.phase       = PH_SP_A;
						end else begin
							nxt.phase  = PH_IDLE;
							flags.done = 1'b1;
						end
					end
					PH_SP_A: begin
						nxt.scl_out = 1'b1; nxt.wait_count = load_val; nxt.phase = PH_SP_B;
					end
					PH_SP_B: begin
						nxt.sda_out = 1'b1; nxt.wait_count = load_val; nxt.phase = PH_SP_C;
					end
					PH_SP_C: begin
						nxt.phase  = PH_IDLE;
						flags.done = 1'b1;
					end
					PH_RD_PRE: begin
						nxt.scl_out = 1'b1; nxt.wait_count = load_val; nxt.phase = PH_RD_HIGH;
					end
					PH_RD_HIGH: begin
						nxt.shift_byte = {cur.shift_byte[6:0], sda_level};
						nxt.scl_out    = 1'b0;
						nxt.wait_count = load_val;
						nxt.phase      = PH_RD_LOW;
					end
					PH_RD_LOW: begin
						nxt.bit_count  = bc_inc;
						nxt.scl_out    = 1'b1;
						nxt.wait_count = load_val;
						if (bc_inc < 4'd8) begin
							nxt.phase = PH_RD_HIGH;
						end else begin
							nxt.sda_dir_out = 1'b1;
							nxt.sda_out     = cur.nack_to_send;
							nxt.phase       = PH_RA_HIGH;
						end
					end
					PH_RA_HIGH: begin
						nxt.scl_out = 1'b0; nxt.wait_count = load_val; nxt.phase = PH_RA_LOW;
					end
					PH_RA_LOW: begin
						nxt.received_byte = cur.shift_byte;
						flags.rvalid      = 1'b1;
						flags.done        = 1'b1;
						nxt.phase         = PH_IDLE;
					end
					default: begin
						nxt.phase = PH_IDLE;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/i2cbm_chk.sv
`default_nettype none

module i2cbm_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic scl_level,
	input wire logic busy_res,
	input wire logic done_res,
	input wire logic read_valid,
	input wire logic rejected
);

	// A stalled result keeps its SCL drive and completion flag.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(scl_level) && $stable(done_res))
		else $error("stalled result changed");

	// A finished sequence leaves the bus idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res)
		else $error("done with bus still busy");

	// A completed read byte always ends its sequence.
	a_read_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_valid |-> done_res)
		else $error("read data without done");

	// A dropped command neither finishes nor delivers data.
	a_rej_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> !done_res && !read_valid)
		else $error("rejected item reported completion");

endmodule

bind i2c_bit_level_master_core i2cbm_chk u_i2cbm_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.scl_level  (scl_level),
	.busy_res   (busy_res),
	.done_res   (done_res),
	.read_valid (read_valid),
	.rejected   (rejected)
);

`default_nettype wire

>>> bench/i2cbm_bus_checker.sv
`timescale 1ns / 1ps

module i2cbm_bus_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [i2cbm_pkg::DELAY_BITS-1:0] cfg_wdata,
	input  wire logic                             in_valid,
	input  wire logic                             in_ready,
	input  wire logic [2:0]                       action,
	input  wire logic                             sda_level,
	input  wire logic [6:0]                       target_addr,
	input  wire logic                             read_dir,
	input  wire logic [7:0]                       data_byte,
	input  wire logic                             send_nack,
	input  wire logic                             out_valid,
	input  wire logic                             out_ready,
	input  wire logic                             scl_level,
	input  wire logic                             sda_release,
	input  wire logic                             sda_output_enable,
	input  wire logic                             busy_res,
	input  wire logic                             done_res,
	input  wire logic [7:0]                       read_data,
	input  wire logic                             read_valid,
	input  wire logic                             ack_error,
	input  wire logic                             rejected,
	output int                                    mismatches,
	output int                                    owed_results
);
	import i2cbm_pkg::*;

	// Line levels and status flags that one item leaves behind.
	typedef struct packed {
		logic       scl;
		logic       sda;
		logic       sda_oe;
		logic       busy;
		logic       done;
		logic [7:0] rx_data;
		logic       rx_valid;
		logic       nack_seen;
		logic       dropped;
	} bus_view_t;

	// Shadow copy of the controller state and its delay register.
	phase_t                ph;
	logic [3:0]            bit_idx;
	logic [7:0]            shifter;
	logic [DELAY_BITS-1:0] ticks_left;
	logic [DELAY_BITS-1:0] ticks_per_phase;
	logic                  scl_q;
	logic                  sda_q;
	logic                  sda_oe_q;
	logic                  nack_q;
	logic                  err_q;
	logic [7:0]            rx_q;

	bus_view_t             due_q[$];
	bus_view_t             want;

	task automatic reset_model();
		ticks_per_phase = DELAY_RST;
		ph              = PH_IDLE;
		bit_idx         = '0;
		shifter         = '0;
		ticks_left      = '0;
		scl_q           = 1'b1;
		sda_q           = 1'b1;
		sda_oe_q        = 1'b1;
		nack_q          = 1'b0;
		err_q           = 1'b0;
		rx_q            = '0;
	endtask

	// A zero delay still waits one tick per phase.
	task automatic reload_wait();
		ticks_left = (ticks_per_phase == '0) ? DELAY_BITS'(1) : ticks_per_phase;
	endtask

	task automatic present_bit();
		sda_oe_q = 1'b1;
		sda_q    = shifter[7];
		reload_wait();
		ph       = PH_WR_SETUP;
	endtask

	task automatic launch_stop();
		sda_oe_q = 1'b1;
		sda_q    = 1'b0;
		reload_wait();
		ph       = PH_SP_A;
	endtask

	// Apply one item to the shadow state and return the lines it produces.
	task automatic advance_bus(input logic [2:0] act, input logic sda_in,
			input logic [6:0] addr, input logic rdir, input logic [7:0] dbyte,
			input logic nack, output bus_view_t v);
		logic fin;
		logic rxv;
		logic drop;
		fin  = 1'b0;
		rxv  = 1'b0;
		drop = 1'b0;
		if (act >= ACT_START && act <= ACT_STOP) begin
			// Commands are taken only while the bus is idle.
			if (ph != PH_IDLE) begin
				drop = 1'b1;
			end else if (act == ACT_START) begin
				err_q    = 1'b0;
				shifter  = {addr, rdir};
				bit_idx  = '0;
				sda_oe_q = 1'b1;
				sda_q    = 1'b1;
				scl_q    = 1'b1;
				reload_wait();
				ph       = PH_ST_A;
			end else if (act == ACT_STOP) begin
				launch_stop();
			end else if (err_q) begin
				drop = 1'b1;
			end else if (act == ACT_WRITE) begin
				shifter = dbyte;
				bit_idx = '0;
				present_bit();
			end else begin
				nack_q   = nack;
				shifter  = '0;
				bit_idx  = '0;
				sda_q    = 1'b1;
				sda_oe_q = 1'b0;
				reload_wait();
				ph       = PH_RD_PRE;
			end
		end else if (ph != PH_IDLE) begin
			// Tick items count down the wait; the last one moves the phase on.
			if (ticks_left != '0)
				ticks_left--;
			if (ticks_left == '0) begin
				case (ph)
					PH_ST_A: begin
						sda_q = 1'b0;
						reload_wait();
						ph = PH_ST_B;
					end
					PH_ST_B: begin
						scl_q = 1'b0;
						reload_wait();
						ph = PH_ST_C;
					end
					PH_ST_C: present_bit();
					PH_WR_SETUP: begin
						scl_q = 1'b1;
						reload_wait();
						ph = PH_WR_HIGH;
					end
					PH_WR_HIGH: begin
						scl_q = 1'b0;
						reload_wait();
						ph = PH_WR_LOW;
					end
					PH_WR_LOW: begin
						bit_idx = bit_idx + 4'd1;
						shifter = {shifter[6:0], 1'b0};
						if (bit_idx < 4'd8) begin
							present_bit();
						end else begin
							sda_oe_q = 1'b0;
							sda_q    = 1'b1;
							reload_wait();
							ph       = PH_AK_SETUP;
						end
					end
					PH_AK_SETUP: begin
						scl_q = 1'b1;
						reload_wait();
						ph = PH_AK_HIGH;
					end
					PH_AK_HIGH: begin
						if (sda_in)
							err_q = 1'b1;
						scl_q = 1'b0;
						reload_wait();
						ph = PH_AK_LOW;
					end
					PH_AK_LOW: begin
						if (err_q) begin
							launch_stop();
						end else begin
							ph  = PH_IDLE;
							fin = 1'b1;
						end
					end
					PH_SP_A: begin
						scl_q = 1'b1;
						reload_wait();
						ph = PH_SP_B;
					end
					PH_SP_B: begin
						sda_q = 1'b1;
						reload_wait();
						ph = PH_SP_C;
					end
					PH_SP_C: begin
						ph  = PH_IDLE;
						fin = 1'b1;
					end
					PH_RD_PRE: begin
						scl_q = 1'b1;
						reload_wait();
						ph = PH_RD_HIGH;
					end
					PH_RD_HIGH: begin
						shifter = {shifter[6:0], sda_in};
						scl_q   = 1'b0;
						reload_wait();
						ph      = PH_RD_LOW;
					end
					PH_RD_LOW: begin
						bit_idx = bit_idx + 4'd1;
						if (bit_idx < 4'd8) begin
							scl_q = 1'b1;
							reload_wait();
							ph    = PH_RD_HIGH;
						end else begin
							sda_oe_q = 1'b1;
							sda_q    = nack_q;
							scl_q    = 1'b1;
							reload_wait();
							ph       = PH_RA_HIGH;
						end
					end
					PH_RA_HIGH: begin
						scl_q = 1'b0;
						reload_wait();
						ph = PH_RA_LOW;
					end
					PH_RA_LOW: begin
						rx_q = shifter;
						rxv  = 1'b1;
						fin  = 1'b1;
						ph   = PH_IDLE;
					end
					default: ph = PH_IDLE;
				endcase
			end
		end
		v.scl       = scl_q;
		v.sda       = sda_q;
		v.sda_oe    = sda_oe_q;
		v.busy      = (ph != PH_IDLE);
		v.done      = fin;
		v.rx_data   = rx_q;
		v.rx_valid  = rxv;
		v.nack_seen = err_q;
		v.dropped   = drop;
	endtask

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, actual %0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			reset_model();
			due_q.delete();
			mismatches = 0;
		end else begin
			// Score each result item against the oldest prediction.
			if (out_valid && out_ready) begin
				if (due_q.size() == 0) begin
					$error("result item with no prediction waiting");
					mismatches++;
				end else begin
					want = due_q.pop_front();
					check_field("scl_level", want.scl, scl_level);
					check_field("sda_release", want.sda, sda_release);
					check_field("sda_output_enable", want.sda_oe, sda_output_enable);
					check_field("busy_res", want.busy, busy_res);
					check_field("done_res", want.done, done_res);
					check_field("read_data", want.rx_data, read_data);
					check_field("read_valid", want.rx_valid, read_valid);
					check_field("ack_error", want.nack_seen, ack_error);
					check_field("rejected", want.dropped, rejected);
				end
			end

			// Predict the result of each accepted input item.
			if (in_valid && in_ready) begin
				advance_bus(action, sda_level, target_addr, read_dir, data_byte, send_nack,
					want);
				due_q.push_back(want);
			end

			// A register write applies from the next item on.
			if (cfg_we)
				ticks_per_phase = cfg_wdata;
		end
		owed_results <= due_q.size();
	end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import i2cbm_pkg::*;

	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_AT     = 1000;
	localparam int LONG_HOLD   = 400;

	// Levels fed to the SDA sample on tick items.
	localparam int FILL_RANDOM = 0;
	localparam int FILL_ONES   = 1;
	localparam int FILL_ZEROS  = 2;

	// Receiver stall patterns.
	localparam int RX_FULL      = 0;
	localparam int RX_MOSTLY    = 1;
	localparam int RX_HALF      = 2;
	localparam int RX_ALTERNATE = 3;

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_we      = 1'b0;
	logic [DELAY_BITS-1:0] cfg_wdata   = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	logic [2:0]            action      = ACT_TICK;
	logic                  sda_level   = 1'b0;
	logic [6:0]            target_addr = '0;
	logic                  read_dir    = 1'b0;
	logic [7:0]            data_byte   = '0;
	logic                  send_nack   = 1'b0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic                  scl_level;
	logic                  sda_release;
	logic                  sda_output_enable;
	logic                  busy_res;
	logic                  done_res;
	logic [7:0]            read_data;
	logic                  read_valid;
	logic                  ack_error;
	logic                  rejected;

	int                    mismatches;
	int                    owed_results;
	logic [DELAY_BITS-1:0] delay_now   = DELAY_RST;
	int                    burst_left  = 0;
	int                    max_gap     = 8;
	int                    items_sent  = 0;
	int                    idle_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	i2c_bit_level_master_core u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.action            (action),
		.sda_level         (sda_level),
		.target_addr       (target_addr),
		.read_dir          (read_dir),
		.data_byte         (data_byte),
		.send_nack         (send_nack),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.scl_level         (scl_level),
		.sda_release       (sda_release),
		.sda_output_enable (sda_output_enable),
		.busy_res          (busy_res),
		.done_res          (done_res),
		.read_data         (read_data),
		.read_valid        (read_valid),
		.ack_error         (ack_error),
		.rejected          (rejected)
	);

	i2cbm_bus_checker u_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.action            (action),
		.sda_level         (sda_level),
		.target_addr       (target_addr),
		.read_dir          (read_dir),
		.data_byte         (data_byte),
		.send_nack         (send_nack),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.scl_level         (scl_level),
		.sda_release       (sda_release),
		.sda_output_enable (sda_output_enable),
		.busy_res          (busy_res),
		.done_res          (done_res),
		.read_data         (read_data),
		.read_valid        (read_valid),
		.ack_error         (ack_error),
		.rejected          (rejected),
		.mismatches        (mismatches),
		.owed_results      (owed_results)
	);

	// Ticks that one bus phase takes at the current setting.
	function automatic int phase_ticks();
		return (delay_now == '0) ? 1 : int'(delay_now);
	endfunction

	// Offer one item and hold it until accepted; gaps fall between bursts.
	task automatic send_item(input logic [2:0] act, input logic lvl, input logic [6:0] addr,
			input logic rdir, input logic [7:0] dbyte, input logic nack);
		int gap;
		if (burst_left == 0) begin
			gap        = $urandom_range(0, max_gap);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid    <= 1'b1;
		action      <= act;
		sda_level   <= lvl;
		target_addr <= addr;
		read_dir    <= rdir;
		data_byte   <= dbyte;
		send_nack   <= nack;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Issue a command and follow it with tick items. With no tick count given,
	// enough ticks are sent to finish it, and the ACK sample gets the wanted level.
	task automatic do_command(input logic [2:0] act, input logic [6:0] addr, input logic rdir,
			input logic [7:0] dbyte, input logic nack_v, input logic want_nack,
			input int fill, input int n_ticks);
		int       d;
		int       waits;
		int       ack_at;
		int       n;
		logic     lvl;
		logic [2:0] tick_act;
		d      = phase_ticks();
		waits  = 0;
		ack_at = 0;
		case (act)
			ACT_START: begin
				waits  = 30;
				ack_at = 29 * d;
			end
			ACT_WRITE: begin
				waits  = 27;
				ack_at = 26 * d;
			end
			ACT_READ:  waits = 19;
			ACT_STOP:  waits = 3;
			default:   waits = 0;
		endcase
		if (n_ticks >= 0)
			n = n_ticks;
		else
			n = (waits + (want_nack ? 3 : 0)) * d + $urandom_range(0, 2);
		send_item(act, 1'($urandom), addr, rdir, dbyte, nack_v);
		for (int i = 1; i <= n; i++) begin
			case (fill)
				FILL_ONES:  lvl = 1'b1;
				FILL_ZEROS: lvl = 1'b0;
				default:    lvl = 1'($urandom);
			endcase
			if (i == ack_at)
				lvl = want_nack;
			// Now and then an unused action code stands in for a tick.
			if ($urandom_range(0, 9) == 0)
				tick_act = ACT_STOP + 3'($urandom_range(1, 3));
			else
				tick_act = ACT_TICK;
			send_item(tick_act, lvl, 7'($urandom), 1'($urandom), 8'($urandom),
				1'($urandom));
		end
	endtask

	// Enough ticks to run out any sequence, a NACK-driven stop included.
	task automatic settle_bus();
		do_command(ACT_TICK, '0, 1'b0, '0, 1'b0, 1'b0, FILL_RANDOM, 40 * phase_ticks());
	endtask

	task automatic set_delay(input logic [DELAY_BITS-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed_results != 0)
			@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		delay_now = v;
	endtask

	// Mostly complete transfers with random content, plus noise and broken ones.
	task automatic random_traffic(input int budget);
		int first;
		int pick;
		int fill;
		first = items_sent;
		while (items_sent - first < budget) begin
			pick = $urandom_range(0, 9);
			if (pick < 8) begin
				do_command(ACT_START, 7'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
					$urandom_range(0, 15) == 0, FILL_RANDOM, -1);
				repeat ($urandom_range(1, 4)) begin
					fill = $urandom_range(0, 7);
					if (fill > FILL_ZEROS)
						fill = FILL_RANDOM;
					if ($urandom_range(0, 1))
						do_command(ACT_WRITE, 7'($urandom), 1'($urandom), 8'($urandom),
							1'($urandom), $urandom_range(0, 11) == 0, fill, -1);
					else
						do_command(ACT_READ, 7'($urandom), 1'($urandom), 8'($urandom),
							1'($urandom), 1'b0, fill, -1);
				end
				do_command(ACT_STOP, 7'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
					1'b0, FILL_RANDOM, -1);
			end else if (pick == 8) begin
				// Any action code with a random, often too short, run of ticks.
				do_command(3'($urandom), 7'($urandom), 1'($urandom), 8'($urandom),
					1'($urandom), 1'($urandom), FILL_RANDOM, $urandom_range(0, 40));
			end else begin
				// A start cut short, so the next command lands while busy.
				do_command(ACT_START, 7'($urandom), 1'($urandom), 8'($urandom), 1'($urandom),
					1'b0, FILL_RANDOM, $urandom_range(1, 20));
				do_command(3'($urandom_range(ACT_START, ACT_STOP)), 7'($urandom), 1'($urandom),
					8'($urandom), 1'($urandom), 1'b0, FILL_RANDOM, -1);
			end
		end
		settle_bus();
	endtask

	// Receiver: random stall patterns, and one long hold-off that backs up the input.
	initial begin : receiver
		int mode;
		int span;
		int cyc;
		mode = RX_FULL;
		span = 0;
		cyc  = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (span == 0) begin
				mode = $urandom_range(RX_FULL, RX_ALTERNATE);
				span = $urandom_range(8, 64);
			end
			span--;
			if (cyc >= HOLD_AT && cyc < HOLD_AT + LONG_HOLD)
				out_ready <= 1'b0;
			else begin
				case (mode)
					RX_FULL:   out_ready <= 1'b1;
					RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
					RX_HALF:   out_ready <= 1'($urandom);
					default:   out_ready <= cyc[0];
				endcase
			end
		end
	end

	// Watchdog: too long without any item moving ends the run.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: a byte with no start at the reset delay.
		do_command(ACT_TICK, 7'h00, 1'b0, 8'h00, 1'b0, 1'b0, FILL_RANDOM, 0);
		do_command(ACT_WRITE, 7'h00, 1'b0, 8'hA5, 1'b0, 1'b0, FILL_RANDOM, -1);

		// The rest of the directed part runs at the shortest delay.
		set_delay(DELAY_BITS'(1));
		do_command(ACT_START, 7'h7F, 1'b0, 8'h00, 1'b0, 1'b0, FILL_ONES, -1);
		do_command(ACT_WRITE, 7'h00, 1'b0, 8'hFF, 1'b0, 1'b0, FILL_RANDOM, -1);
		do_command(ACT_WRITE, 7'h7F, 1'b1, 8'h00, 1'b1, 1'b0, FILL_RANDOM, -1);
		do_command(ACT_READ, 7'h00, 1'b0, 8'h00, 1'b0, 1'b0, FILL_ONES, -1);
		// Repeated start between bytes, then a NACKed last read.
		do_command(ACT_START, 7'h00, 1'b1, 8'h00, 1'b0, 1'b0, FILL_RANDOM, -1);
		do_command(ACT_READ, 7'h00, 1'b0, 8'h00, 1'b1, 1'b0, FILL_ZEROS, -1);
		do_command(ACT_STOP, 7'h00, 1'b0, 8'h00, 1'b0, 1'b0, FILL_RANDOM, -1);
		// Command while busy.
		do_command(ACT_START, 7'h2A, 1'b0, 8'h00, 1'b0, 1'b0, FILL_RANDOM, 3);
		do_command(ACT_WRITE, 7'h00, 1'b0, 8'h3C, 1'b0, 1'b0, FILL_RANDOM,
			40 * phase_ticks());
		// NACK on the address, then byte commands in error and a stop.
		do_command(ACT_START, 7'h55, 1'b1, 8'h00, 1'b0, 1'b1, FILL_RANDOM, -1);
		do_command(ACT_WRITE, 7'h00, 1'b0, 8'h81, 1'b0, 1'b0, FILL_RANDOM, 0);
		do_command(ACT_READ, 7'h00, 1'b0, 8'h00, 1'b0, 1'b0, FILL_RANDOM, 0);
		do_command(ACT_STOP, 7'h00, 1'b0, 8'h00, 1'b0, 1'b0, FILL_RANDOM, -1);
		// A new start clears the error.
		do_command(ACT_START, 7'h13, 1'b0, 8'h00, 1'b0, 1'b0, FILL_RANDOM, -1);
		do_command(ACT_STOP, 7'h00, 1'b0, 8'h00, 1'b0, 1'b0, FILL_RANDOM, -1);
		settle_bus();

		// Random part over several delay settings, zero among them.
		random_traffic(550);
		set_delay('0);
		random_traffic(180);
		set_delay(DELAY_BITS'(2));
		random_traffic(220);

		// Largest delay: the opening of a stop sequence, sent without gaps.
		set_delay('1);
		max_gap = 0;
		do_command(ACT_STOP, 7'h00, 1'b0, 8'h00, 1'b0, 1'b0, FILL_RANDOM, 40);

		// Drain the outstanding results, then give the verdict.
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed_results != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
